@@ rtl/core/swm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding-window median checker.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W = 20;  // signed sample width
  localparam int HW_W     = 7;   // half_window register width
  localparam int COUNT_W  = 8;   // at_or_above_count field width
  localparam int TALLY_W  = 32;  // median_tally field width
  localparam int IN_W     = 24;  // s_tdata width (sample padded to bytes)
  localparam int OUT_W    = 48;  // m_tdata width (41 bits padded to bytes)

  localparam logic [HW_W-1:0] HW_RESET = HW_W'(1);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CENTRE,
    ST_COUNT,
    ST_DONE
  } seq_state_t;

  // Controls broadcast to every cell of the window chain
  typedef struct packed {
    logic shift_win;   // take a new sample into the window chain
    logic load_scan;   // copy window into the scan chain
    logic shift_scan;  // move scan chain one cell toward the head
  } cell_ctrl_t;

endpackage

@@ rtl/core/sliding_window_median_test_unit.sv @@
`timescale 1ns / 1ps
// Flow: a sample that completes no window is only shifted into the window chain; one
//   that completes a window passes ST_LOAD, ST_CENTRE, ST_COUNT, ST_DONE to its result register.
// Occupancy: one item at a time; new samples are taken only in ST_IDLE, and ST_DONE
//   holds while the last result is not yet taken. The single head comparator walks the
//   scan chain, first to reach the centre and then to count the neighbors.
// Reset: synchronous, active high; clears fill level, tally, state and output
//   valid, and sets half_window to 1. Window cells are read only once written.
// ----------------------------------------------------------------------------
// sliding_window_median_test_unit
// Sliding-window median check over a chain of sample cells.
// ----------------------------------------------------------------------------
module sliding_window_median_test_unit #(
  parameter int MAX_HALF = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // input requests
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [swm_pkg::IN_W-1:0]         s_tdata,   // [19:0] sample, [23:20] zero
  input  logic                             s_tlast,   // last_sample
  // configuration (half_window)
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swm_pkg::HW_W-1:0]         cfg_data,
  // results
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [swm_pkg::OUT_W-1:0]        m_tdata    // [0] is_median,
                                                      // [8:1] at_or_above_count,
                                                      // [40:9] median_tally, rest 0
);

  localparam int DEPTH = 2 * MAX_HALF + 1;

  swm_pkg::cell_ctrl_t                  ctrl;
  logic signed [swm_pkg::SAMPLE_W-1:0]  sample;
  logic signed [swm_pkg::SAMPLE_W-1:0]  win_chain  [DEPTH];
  logic signed [swm_pkg::SAMPLE_W-1:0]  scan_chain [DEPTH];

  assign sample = $signed(s_tdata[swm_pkg::SAMPLE_W-1:0]);

  // window chain, newest sample at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [swm_pkg::SAMPLE_W-1:0] win_in;
    logic signed [swm_pkg::SAMPLE_W-1:0] scan_in;

    if (i == 0) begin : g_head
      assign win_in = sample;
    end else begin : g_body
      assign win_in = win_chain[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign scan_in = '0;
    end else begin : g_inner
      assign scan_in = scan_chain[i+1];
    end

    swm_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .win_in  (win_in),
      .scan_in (scan_in),
      .win     (win_chain[i]),
      .scan    (scan_chain[i])
    );
  end

  // sequencer
  swm_seq #(
    .MAX_HALF (MAX_HALF)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .scan_head (scan_chain[0]),
    .ctrl      (ctrl),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ rtl/core/swm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One window position: a stored sample and a scan copy that walks to the head.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic                                  clk,
  input  swm_pkg::cell_ctrl_t                   ctrl,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]   win_in,   // from younger neighbor
  input  logic signed [swm_pkg::SAMPLE_W-1:0]   scan_in,  // from older neighbor
  output logic signed [swm_pkg::SAMPLE_W-1:0]   win,
  output logic signed [swm_pkg::SAMPLE_W-1:0]   scan
);

  // window shift line
  always_ff @(posedge clk) begin
    if (ctrl.shift_win) begin
      win <= win_in;
    end
  end

  // scan copy: reload from window or step toward the head
  always_ff @(posedge clk) begin
    if (ctrl.load_scan) begin
      scan <= win;
    end else if (ctrl.shift_scan) begin
      scan <= scan_in;
    end
  end

endmodule

@@ rtl/core/swm_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_seq
// Sequencer: fill tracking, centre pick-up, neighbor count, tally, output reg.
// ----------------------------------------------------------------------------
module swm_seq #(
  parameter int MAX_HALF = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input request side
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic                                 s_tlast,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swm_pkg::HW_W-1:0]             cfg_data,
  // head of the scan chain
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  scan_head,
  output swm_pkg::cell_ctrl_t                  ctrl,
  // result side
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [swm_pkg::OUT_W-1:0]            m_tdata
);

  localparam int DEPTH  = 2 * MAX_HALF + 1;
  localparam int LH_W   = $clog2(MAX_HALF + 1);
  localparam int SPAN_W = $clog2(2 * MAX_HALF + 2);
  localparam int PAD_W  = swm_pkg::OUT_W - 1 - swm_pkg::COUNT_W - swm_pkg::TALLY_W;

  swm_pkg::seq_state_t state, state_next;

  logic [swm_pkg::HW_W-1:0]           half_window;
  logic [LH_W-1:0]                    lh, lh_next;
  logic [SPAN_W-1:0]                  span, span_next;
  logic [SPAN_W-1:0]                  fill, fill_next;
  logic [SPAN_W-1:0]                  fill_inc;
  logic [SPAN_W-1:0]                  cnt, cnt_next;
  logic [SPAN_W-1:0]                  count, count_next;
  logic                               last_q, last_q_next;
  logic signed [swm_pkg::SAMPLE_W-1:0] centre, centre_next;
  logic [swm_pkg::TALLY_W-1:0]        tally, tally_next;
  logic [swm_pkg::TALLY_W-1:0]        tally_upd;
  logic                               median;
  logic                               out_valid_next;
  logic [swm_pkg::OUT_W-1:0]          out_data_next;
  logic                               accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == swm_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= swm_pkg::HW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_window <= cfg_data;
    end
  end

  // effective half window, saturated to MAX_HALF
  always_comb begin
    if (32'(half_window) > MAX_HALF) begin
      lh_next = LH_W'(MAX_HALF);
    end else begin
      lh_next = LH_W'(half_window);
    end
    span_next = (SPAN_W'(lh_next) << 1) | SPAN_W'(1);
    fill_inc  = (fill == SPAN_W'(DEPTH)) ? fill : fill + SPAN_W'(1);
  end

  // result of the finished count
  always_comb begin
    median    = (count == SPAN_W'(lh));
    tally_upd = (median && (tally != '1)) ? tally + swm_pkg::TALLY_W'(1) : tally;
  end

  // next state and datapath control
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    cnt_next       = cnt;
    count_next     = count;
    last_q_next    = last_q;
    centre_next    = centre;
    tally_next     = tally;
    out_valid_next = m_tvalid && !m_tready;
    out_data_next  = m_tdata;
    ctrl           = '0;

    unique case (state)
      swm_pkg::ST_IDLE: begin
        if (accept) begin
          ctrl.shift_win = 1'b1;
          last_q_next    = s_tlast;
          fill_next      = s_tlast ? '0 : fill_inc;
          if (fill_inc >= span_next) begin
            state_next = swm_pkg::ST_LOAD;
          end else if (s_tlast) begin
            tally_next = '0;
          end
        end
      end
      swm_pkg::ST_LOAD: begin
        ctrl.load_scan = 1'b1;
        cnt_next       = '0;
        count_next     = '0;
        state_next     = swm_pkg::ST_CENTRE;
      end
      // walk the scan chain until the centre reaches the head
      swm_pkg::ST_CENTRE: begin
        if (cnt == SPAN_W'(lh)) begin
          centre_next    = scan_head;
          ctrl.load_scan = 1'b1;
          cnt_next       = '0;
          state_next     = swm_pkg::ST_COUNT;
        end else begin
          ctrl.shift_scan = 1'b1;
          cnt_next        = cnt + SPAN_W'(1);
        end
      end
      // one window cell per cycle at the head; each neighbor (not the centre) is compared
      swm_pkg::ST_COUNT: begin
        ctrl.shift_scan = 1'b1;
        if ((cnt != SPAN_W'(lh)) && (scan_head >= centre)) begin
          count_next = count + SPAN_W'(1);
        end
        cnt_next = cnt + SPAN_W'(1);
        if (cnt == span - SPAN_W'(1)) begin
          state_next = swm_pkg::ST_DONE;
        end
      end
      swm_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {{PAD_W{1'b0}}, tally_upd,
                            swm_pkg::COUNT_W'(count), median};
          tally_next     = last_q ? '0 : tally_upd;
          state_next     = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swm_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= swm_pkg::ST_IDLE;
      fill     <= '0;
      tally    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      tally    <= tally_next;
      m_tvalid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lh   <= lh_next;
      span <= span_next;
    end
    cnt     <= cnt_next;
    count   <= count_next;
    last_q  <= last_q_next;
    centre  <= centre_next;
    m_tdata <= out_data_next;
  end

endmodule
